// ===== hdl/dbt_pkg.sv =====
package dbt_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = 4;
	localparam int SAMPLE_W     = 16;
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_ODD   = 2'd1,
		PH_EVEN  = 2'd2
	} phase_t;

	// Per-request slot decode shared by history and output logic.
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            first;
		logic            emit;
		logic            last;
	} slot_t;

endpackage

// ===== hdl/dbt_ctrl.sv =====
module dbt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      starts_stream,
	input  logic [dbt_pkg::CNT_W-1:0] count,
	output dbt_pkg::slot_t            slot
);
	import dbt_pkg::*;

	logic [CH_W-1:0] pos_q;
	phase_t          phase_q;
	logic [CH_W-1:0] pos0;
	phase_t          phase0;
	phase_t          phase_nx;
	logic [CNT_W-1:0] ch_plus1;

	always_comb begin
		pos0   = starts_stream ? '0 : pos_q;
		phase0 = starts_stream ? PH_FIRST : phase_q;
		// position beyond a lowered count wraps to channel 0
		slot.ch = ({{(CNT_W-CH_W){1'b0}}, pos0} >= count) ? '0 : pos0;
		ch_plus1 = {{(CNT_W-CH_W){1'b0}}, slot.ch} + CNT_W'(1);
		slot.last  = (ch_plus1 >= count);
		slot.first = (phase0 == PH_FIRST);
		slot.emit  = (phase0 == PH_EVEN);
		case (phase0)
			PH_ODD:  phase_nx = PH_EVEN;
			default: phase_nx = PH_ODD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_FIRST;
		end else if (accept) begin
			if (slot.last) begin
				pos_q   <= '0;
				phase_q <= phase_nx;
			end else begin
				pos_q   <= ch_plus1[CH_W-1:0];
				phase_q <= phase0;
			end
		end
	end

endmodule

// ===== hdl/dbt_hist.sv =====
module dbt_hist (
	input  logic             clk,
	input  logic             accept,
	input  dbt_pkg::slot_t   slot,
	input  dbt_pkg::sample_t x,
	output dbt_pkg::sample_t older,
	output dbt_pkg::sample_t newer
);
	import dbt_pkg::*;

	sample_t older_q [MAX_CHANNELS];
	sample_t newer_q [MAX_CHANNELS];

	assign older = older_q[slot.ch];
	assign newer = newer_q[slot.ch];

	// odd frames age the history; first and even frames only refresh newer
	always_ff @(posedge clk) begin
		if (accept) begin
			newer_q[slot.ch] <= x;
			if (!slot.first && !slot.emit) begin
				older_q[slot.ch] <= newer_q[slot.ch];
			end
		end
	end

endmodule

// ===== hdl/dbt_filt.sv =====
module dbt_filt (
	input  dbt_pkg::sample_t a,
	input  dbt_pkg::sample_t b,
	input  dbt_pkg::sample_t c,
	output dbt_pkg::sample_t y
);
	import dbt_pkg::*;

	localparam int SUM_W = SAMPLE_W + 2;

	logic signed [SAMPLE_W:0]  a4, b2, c4;
	logic signed [SUM_W-1:0]   sum;

	// divide with truncation toward zero: bias negatives before the shift
	always_comb begin
		a4  = ($signed({a[SAMPLE_W-1], a}) + $signed({15'd0, a[SAMPLE_W-1], a[SAMPLE_W-1]}))
			>>> 2;
		b2  = ($signed({b[SAMPLE_W-1], b}) + $signed({16'd0, b[SAMPLE_W-1]})) >>> 1;
		c4  = ($signed({c[SAMPLE_W-1], c}) + $signed({15'd0, c[SAMPLE_W-1], c[SAMPLE_W-1]}))
			>>> 2;
		sum = SUM_W'(a4) + SUM_W'(b2) + SUM_W'(c4);
		if (sum > SUM_W'(32767)) begin
			y = 16'sh7FFF;
		end else if (sum < -SUM_W'(32768)) begin
			y = 16'sh8000;
		end else begin
			y = sum[SAMPLE_W-1:0];
		end
	end

endmodule

// ===== hdl/decimate_by_two_fir_121.sv =====
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid/s_tready      tdata: sample_in; tuser: starts_stream
// m_*       out  m_tvalid/m_tready      tdata: sample_out, channel; tlast: frame_last
// cfg_*     in   cfg_valid/cfg_ready    cfg_data: channel_count
//
// One request per clock while s_tready is high; an even-frame result appears in the
// cycle after its request is taken, held in the output register. Filter math and
// history update share the accept cycle. Input stalls only while a result sits in
// the output register and m_tready is low. Reset: channel count 2, channel 0, first
// frame; sample history is not cleared. cfg_ready is always high.
module decimate_by_two_fir_121 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_in
	input  logic        s_tuser,   // [0] starts_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] sample_out, [18:16] channel, [23:19] zero
	output logic        m_tlast,   // frame_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // channel_count
);
	import dbt_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_eff;
	logic             accept;
	slot_t            slot;
	sample_t          x, older, newer, y;

	logic             out_valid_q;
	sample_t          out_sample_q;
	logic [CH_W-1:0]  out_ch_q;
	logic             out_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	// zero acts as one channel, large values clamp to the history depth
	always_comb begin
		if (count_q == '0) begin
			count_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_CHANNELS)) begin
			count_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			count_eff = count_q;
		end
	end

	// take a new request whenever the output slot is free or draining
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign x        = s_tdata;

	dbt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.starts_stream (s_tuser),
		.count         (count_eff),
		.slot          (slot)
	);

	dbt_hist u_hist (
		.clk    (clk),
		.accept (accept),
		.slot   (slot),
		.x      (x),
		.older  (older),
		.newer  (newer)
	);

	dbt_filt u_filt (
		.a (older),
		.b (newer),
		.c (x),
		.y (y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= accept && slot.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && slot.emit) begin
			out_sample_q <= y;
			out_ch_q     <= slot.ch;
			out_last_q   <= slot.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_ch_q, out_sample_q};
	assign m_tlast  = out_last_q;

endmodule
